### sv/ir_touch_frame_decoder_defines.svh
// Assertion macros shared by the IR touch frame decoder checkers.
// No dependencies; included by the checker file.
`ifndef IR_TOUCH_FRAME_DECODER_DEFINES_SVH
`define IR_TOUCH_FRAME_DECODER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define IRTFD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define IRTFD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/irtfd_pkg.sv
// Constants and types for the IR touch frame decoder.
// No dependencies; imported by the decoder top level and its checker.
package irtfd_pkg;

  localparam int WIN_LEN     = 21;
  localparam int V_BASE      = 3;
  localparam int H_BASE      = 14;
  localparam int FRAME_BYTES = WIN_LEN - 1 - V_BASE;
  localparam int FRAME_BITS  = FRAME_BYTES * 8;
  localparam int H_BIT_OFS   = (H_BASE - V_BASE) * 8;

  localparam int H_BEAMS_DEF = 48;
  localparam int V_BEAMS_DEF = 76;

  localparam int CX_W = 7;
  localparam int CY_W = 8;

  typedef logic [7:0] byte_t;

  localparam byte_t SOF_0    = 8'h55;  // 'U'
  localparam byte_t SOF_1    = 8'h54;  // 'T'
  localparam byte_t SOF_2    = 8'h4C;  // 'L'
  localparam byte_t SUM_SEED = 8'hFF;
  localparam byte_t SUM_ADD  = 8'hA0;
  localparam byte_t SUM_BIAS = SUM_SEED + SUM_ADD;

endpackage

### sv/ir_touch_frame_decoder.sv
// IR touch frame decoder: one received byte per item in, one touch report per valid frame out.
// The completed frame is held in s1_bits_r, then the decoded report in the out_* registers.
// Throughput: one byte per cycle while in_stall is low; the checksum is kept as a running
// sum, so the frame check needs only a subtract, two adds and a compare in the accept cycle.
// Reset (synchronous, rst_n low) clears the window, running sum, last touch state and
// both valid flags.
module ir_touch_frame_decoder
  import irtfd_pkg::*;
#(
  parameter int H_BEAMS = H_BEAMS_DEF,
  parameter int V_BEAMS = V_BEAMS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [7:0]      in_rx_byte,
  output logic            out_valid,
  input  logic            out_stall,
  output logic            out_touched,
  output logic [CX_W-1:0] out_center_x2,
  output logic [CY_W-1:0] out_center_y2,
  output logic            out_press_edge,
  output logic            out_release_edge
);

  localparam int HIW = $clog2(H_BEAMS);
  localparam int VIW = $clog2(V_BEAMS);
  localparam logic [CY_W-1:0] CY_BASE = CY_W'(2 * (V_BEAMS - 1));

  // Window bytes 1..20; byte 0 is never looked at after the shift.
  byte_t win_r [1:WIN_LEN-1];
  byte_t sum_r;
  byte_t sum_nxt;

  logic                  s1_valid_r;
  logic [FRAME_BITS-1:0] s1_bits_r;
  logic                  last_touch_r;
  logic                  out_valid_r;

  logic in_acc;
  logic out_free;
  logic s1_move;
  logic frame_ok;

  logic [H_BEAMS-1:0] h_bits;
  logic [V_BEAMS-1:0] v_bits;
  logic               h_any;
  logic               v_any;
  logic [HIW-1:0]     h_lo;
  logic [HIW-1:0]     h_hi;
  logic [VIW-1:0]     v_lo;
  logic [VIW-1:0]     v_hi;
  logic               touched;
  logic [CX_W-1:0]    cx;
  logic [CY_W-1:0]    cy;

  assign out_free = !out_valid_r || !out_stall;
  assign s1_move  = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_acc   = in_valid && !in_stall;

  // Sum of bytes 3..19 after the shift: drop old byte 3, add old byte 20.
  assign sum_nxt  = sum_r - win_r[V_BASE] + win_r[WIN_LEN-1];
  assign frame_ok = (win_r[1] == SOF_0) && (win_r[2] == SOF_1) && (win_r[3] == SOF_2) &&
                    (in_rx_byte == byte_t'(sum_nxt + SUM_BIAS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 1; i < WIN_LEN; i++) begin
        win_r[i] <= '0;
      end
      sum_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        if (frame_ok) begin
          for (int i = 1; i < WIN_LEN; i++) begin
            win_r[i] <= '0;
          end
          sum_r <= '0;
        end else begin
          for (int i = 1; i < WIN_LEN - 1; i++) begin
            win_r[i] <= win_r[i+1];
          end
          win_r[WIN_LEN-1] <= in_rx_byte;
          sum_r            <= sum_nxt;
        end
      end
      if (in_acc && frame_ok) begin
        s1_valid_r <= 1'b1;
      end else if (s1_move) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  // Frame payload: window bytes 3..19 as they stand after the shift.
  always_ff @(posedge clk) begin
    if (in_acc && frame_ok) begin
      for (int k = 0; k < FRAME_BYTES; k++) begin
        s1_bits_r[8*k +: 8] <= win_r[V_BASE + 1 + k];
      end
    end
  end

  assign v_bits = s1_bits_r[V_BEAMS-1:0];
  assign h_bits = s1_bits_r[H_BIT_OFS +: H_BEAMS];
  assign h_any  = |h_bits;
  assign v_any  = |v_bits;

  always_comb begin
    h_lo = '0;
    h_hi = '0;
    for (int i = H_BEAMS - 1; i >= 0; i--) begin
      if (h_bits[i]) h_lo = HIW'(i);
    end
    for (int i = 0; i < H_BEAMS; i++) begin
      if (h_bits[i]) h_hi = HIW'(i);
    end
  end

  always_comb begin
    v_lo = '0;
    v_hi = '0;
    for (int i = V_BEAMS - 1; i >= 0; i--) begin
      if (v_bits[i]) v_lo = VIW'(i);
    end
    for (int i = 0; i < V_BEAMS; i++) begin
      if (v_bits[i]) v_hi = VIW'(i);
    end
  end

  // The vertical index is reversed, so the sum of both reversed extremes is
  // 2*(V_BEAMS-1) minus the sum of the raw extremes.
  assign touched = h_any && v_any;
  assign cx = touched ? (CX_W'(h_lo) + CX_W'(h_hi)) : '0;
  assign cy = touched ? (CY_BASE - (CY_W'(v_lo) + CY_W'(v_hi))) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      last_touch_r <= 1'b0;
    end else begin
      if (s1_move) begin
        out_valid_r  <= 1'b1;
        last_touch_r <= touched;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_touched      <= touched;
      out_center_x2    <= cx;
      out_center_y2    <= cy;
      out_press_edge   <= touched && !last_touch_r;
      out_release_edge <= !touched && last_touch_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

### sv/irtfd_checker.sv
// Port-level checker for the IR touch frame decoder, bound to the top level.
// Depends on irtfd_pkg and ir_touch_frame_decoder_defines.svh.
`include "ir_touch_frame_decoder_defines.svh"

module irtfd_checker
  import irtfd_pkg::*;
(
  input logic            clk,
  input logic            rst_n,
  input logic            out_valid,
  input logic            out_stall,
  input logic            out_touched,
  input logic [CX_W-1:0] out_center_x2,
  input logic [CY_W-1:0] out_center_y2,
  input logic            out_press_edge,
  input logic            out_release_edge
);

  `IRTFD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_touched) && $stable(out_center_x2) && $stable(out_center_y2) && $stable(out_press_edge) && $stable(out_release_edge), "stalled result changed")
  `IRTFD_ASSERT_NOW(a_untouched_zero, clk, rst_n, out_valid && !out_touched, (out_center_x2 == '0) && (out_center_y2 == '0), "center not zero without touch")
  `IRTFD_ASSERT_NOW(a_press_touched, clk, rst_n, out_valid && out_press_edge, out_touched, "press edge without touch")
  `IRTFD_ASSERT_NOW(a_release_untouched, clk, rst_n, out_valid && out_release_edge, !out_touched, "release edge while touched")

endmodule

bind ir_touch_frame_decoder irtfd_checker u_irtfd_checker (.*);
